// File: sv/scd_pkg.sv
// Shared types and constants for the serial command decoder.
package scd_pkg;

  localparam int GAUGE_COUNT   = 4;
  localparam int DISPLAY_COUNT = 4;
  localparam int DISPLAY_BYTES = 41;
  localparam int MAX_NOTES     = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int CFG_AW      = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_CODE_GAUGE   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CODE_BRIGHT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CODE_DISPLAY = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CODE_AUDIO   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CODE_FLUSH   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_REPLY_ACK    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_REPLY_BAD    = 3'd6;

  // Result kinds
  localparam logic [2:0] KIND_GAUGE   = 3'd0;
  localparam logic [2:0] KIND_BRIGHT  = 3'd1;
  localparam logic [2:0] KIND_DISPLAY = 3'd2;
  localparam logic [2:0] KIND_NOTE    = 3'd3;
  localparam logic [2:0] KIND_LENGTH  = 3'd4;
  localparam logic [2:0] KIND_REPLY   = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ARG  = 3'd1,
    PH_DATA = 3'd2,
    PH_LOW  = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_GAUGE   = 3'd1,
    CMD_BRIGHT  = 3'd2,
    CMD_DISPLAY = 3'd3,
    CMD_AUDIO   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [7:0] code_gauge;
    logic [7:0] code_bright;
    logic [7:0] code_display;
    logic [7:0] code_audio;
    logic [7:0] code_flush;
    logic [7:0] reply_flush_ack;
    logic [7:0] reply_audio_bad;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  write_kind;
    logic [1:0]  unit;
    logic [5:0]  slot;
    logic [15:0] payload;
    logic        last_of_run;
  } result_t;

endpackage

// File: sv/serial_command_decoder.sv
// Top level of the serial command decoder: code registers, parser and result queue.
//
//   channel   signals                                       direction
//   in        in_valid, in_ready, rx_byte                   into block
//   out       out_valid, out_ready, write_kind, unit,       out of block
//             slot, payload, last_of_run
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data     into block
//
// One received byte is taken per cycle while in_ready is high; its results
// are registered in a four-entry queue before they reach the output.
// The output delivers one result per cycle while out_ready is high, so a byte
// that ends an audio command (note plus length) yields two results.
// in_ready drops while the queue holds more than two results.
// Reset is synchronous; it restores the code registers and returns to idle.
module serial_command_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 write_kind,
  output logic [1:0]                 unit,
  output logic [5:0]                 slot,
  output logic [15:0]                payload,
  output logic                       last_of_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scd_pkg::CFG_AW-1:0] cfg_index,
  input  logic [7:0]                 cfg_data
);

  scd_pkg::cfg_t    cfg;
  scd_pkg::result_t res_first, res_second, head;
  logic [1:0] res_count, push_count;
  logic       take;
  logic       room;

  assign cfg_ready  = 1'b1;
  assign in_ready   = room;
  assign take       = in_valid && room;
  assign push_count = take ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_gauge      <= 8'd1;
      cfg.code_bright     <= 8'd2;
      cfg.code_display    <= 8'd3;
      cfg.code_audio      <= 8'd4;
      cfg.code_flush      <= 8'd5;
      cfg.reply_flush_ack <= 8'd6;
      cfg.reply_audio_bad <= 8'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        scd_pkg::REG_CODE_GAUGE:   cfg.code_gauge      <= cfg_data;
        scd_pkg::REG_CODE_BRIGHT:  cfg.code_bright     <= cfg_data;
        scd_pkg::REG_CODE_DISPLAY: cfg.code_display    <= cfg_data;
        scd_pkg::REG_CODE_AUDIO:   cfg.code_audio      <= cfg_data;
        scd_pkg::REG_CODE_FLUSH:   cfg.code_flush      <= cfg_data;
        scd_pkg::REG_REPLY_ACK:    cfg.reply_flush_ack <= cfg_data;
        scd_pkg::REG_REPLY_BAD:    cfg.reply_audio_bad <= cfg_data;
        default: ;
      endcase
    end
  end

  scd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx_byte    (rx_byte),
    .cfg        (cfg),
    .res_first  (res_first),
    .res_second (res_second),
    .res_count  (res_count)
  );

  scd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (res_first),
    .push_second (res_second),
    .room        (room),
    .head_valid  (out_valid),
    .head_ready  (out_ready),
    .head        (head)
  );

  assign write_kind  = head.write_kind;
  assign unit        = head.unit;
  assign slot        = head.slot;
  assign payload     = head.payload;
  assign last_of_run = head.last_of_run;

endmodule

// File: sv/scd_parser.sv
// Frame parser: command state and the results caused by each received byte.
module scd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  input  scd_pkg::cfg_t         cfg,
  output scd_pkg::result_t      res_first,
  output scd_pkg::result_t      res_second,
  output logic [1:0]            res_count
);

  scd_pkg::phase_t phase, phase_next;
  scd_pkg::cmd_t   command, command_next;
  logic [7:0] target_index, target_index_next;
  logic [5:0] byte_position, byte_position_next;
  logic [5:0] note_total, note_total_next;
  logic [8:0] skip_remaining, skip_remaining_next;
  logic [7:0] note_high_hold, note_high_hold_next;

  logic [5:0] pos_inc;
  logic [8:0] skip_dec;
  logic       audio_big;
  logic       display_end;
  logic       note_end;
  logic       gauge_ok;
  logic       display_ok;

  assign pos_inc     = byte_position + 6'd1;
  assign skip_dec    = (skip_remaining != 9'd0) ? skip_remaining - 9'd1 : 9'd0;
  assign audio_big   = rx_byte >= 8'(scd_pkg::MAX_NOTES);
  assign display_end = ({1'b0, pos_inc} >= 7'(scd_pkg::DISPLAY_BYTES)) || (pos_inc == 6'd0);
  assign note_end    = (pos_inc >= note_total) || (pos_inc == 6'd0);
  assign gauge_ok    = target_index < 8'(scd_pkg::GAUGE_COUNT);
  assign display_ok  = target_index < 8'(scd_pkg::DISPLAY_COUNT);

  always_comb begin
    phase_next          = phase;
    command_next        = command;
    target_index_next   = target_index;
    byte_position_next  = byte_position;
    note_total_next     = note_total;
    skip_remaining_next = skip_remaining;
    note_high_hold_next = note_high_hold;
    case (phase)
      scd_pkg::PH_ARG: begin
        if (command == scd_pkg::CMD_AUDIO) begin
          if (audio_big) begin
            skip_remaining_next = {rx_byte, 1'b0};
            if ({rx_byte, 1'b0} == 9'd0) begin
              phase_next   = scd_pkg::PH_IDLE;
              command_next = scd_pkg::CMD_NONE;
            end else begin
              phase_next = scd_pkg::PH_SKIP;
            end
          end else if (rx_byte == 8'd0) begin
            phase_next   = scd_pkg::PH_IDLE;
            command_next = scd_pkg::CMD_NONE;
          end else begin
            note_total_next    = rx_byte[5:0];
            byte_position_next = 6'd0;
            phase_next         = scd_pkg::PH_DATA;
          end
        end else if (command == scd_pkg::CMD_GAUGE || command == scd_pkg::CMD_DISPLAY) begin
          target_index_next  = rx_byte;
          byte_position_next = 6'd0;
          phase_next         = scd_pkg::PH_DATA;
        end else begin
          phase_next   = scd_pkg::PH_IDLE;
          command_next = scd_pkg::CMD_NONE;
        end
      end
      scd_pkg::PH_DATA: begin
        if (command == scd_pkg::CMD_DISPLAY) begin
          byte_position_next = pos_inc;
          if (display_end) begin
            phase_next   = scd_pkg::PH_IDLE;
            command_next = scd_pkg::CMD_NONE;
          end
        end else if (command == scd_pkg::CMD_AUDIO) begin
          note_high_hold_next = rx_byte;
          phase_next          = scd_pkg::PH_LOW;
        end else begin
          phase_next   = scd_pkg::PH_IDLE;
          command_next = scd_pkg::CMD_NONE;
        end
      end
      scd_pkg::PH_LOW: begin
        byte_position_next = pos_inc;
        if (note_end) begin
          phase_next   = scd_pkg::PH_IDLE;
          command_next = scd_pkg::CMD_NONE;
        end else begin
          phase_next = scd_pkg::PH_DATA;
        end
      end
      scd_pkg::PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 9'd0) begin
          phase_next   = scd_pkg::PH_IDLE;
          command_next = scd_pkg::CMD_NONE;
        end
      end
      default: begin
        // Idle, and any code that means nothing, looks for a command byte
        phase_next   = scd_pkg::PH_IDLE;
        command_next = scd_pkg::CMD_NONE;
        if (rx_byte == cfg.code_gauge) begin
          command_next = scd_pkg::CMD_GAUGE;
          phase_next   = scd_pkg::PH_ARG;
        end else if (rx_byte == cfg.code_bright) begin
          command_next = scd_pkg::CMD_BRIGHT;
          phase_next   = scd_pkg::PH_DATA;
        end else if (rx_byte == cfg.code_display) begin
          command_next = scd_pkg::CMD_DISPLAY;
          phase_next   = scd_pkg::PH_ARG;
        end else if (rx_byte == cfg.code_audio) begin
          command_next = scd_pkg::CMD_AUDIO;
          phase_next   = scd_pkg::PH_ARG;
        end
      end
    endcase
  end

  always_comb begin
    res_first  = '0;
    res_second = '0;
    res_count  = 2'd0;
    case (phase)
      scd_pkg::PH_ARG: begin
        if (command == scd_pkg::CMD_AUDIO) begin
          if (audio_big) begin
            res_first.write_kind  = scd_pkg::KIND_REPLY;
            res_first.payload     = {8'd0, cfg.reply_audio_bad};
            res_first.last_of_run = 1'b1;
            res_count             = 2'd1;
          end else if (rx_byte == 8'd0) begin
            res_first.write_kind  = scd_pkg::KIND_LENGTH;
            res_first.last_of_run = 1'b1;
            res_count             = 2'd1;
          end
        end
      end
      scd_pkg::PH_DATA: begin
        if (command == scd_pkg::CMD_GAUGE) begin
          if (gauge_ok) begin
            res_first.write_kind  = scd_pkg::KIND_GAUGE;
            res_first.unit        = target_index[1:0];
            res_first.payload     = {8'd0, rx_byte};
            res_first.last_of_run = 1'b1;
            res_count             = 2'd1;
          end
        end else if (command == scd_pkg::CMD_BRIGHT) begin
          res_first.write_kind  = scd_pkg::KIND_BRIGHT;
          res_first.payload     = {8'd0, rx_byte};
          res_first.last_of_run = 1'b1;
          res_count             = 2'd1;
        end else if (command == scd_pkg::CMD_DISPLAY) begin
          if (display_ok) begin
            res_first.write_kind  = scd_pkg::KIND_DISPLAY;
            res_first.unit        = target_index[1:0];
            res_first.slot        = byte_position;
            res_first.payload     = {8'd0, rx_byte};
            res_first.last_of_run = 1'b1;
            res_count             = 2'd1;
          end
        end
      end
      scd_pkg::PH_LOW: begin
        res_first.write_kind = scd_pkg::KIND_NOTE;
        res_first.slot       = byte_position;
        res_first.payload    = {note_high_hold, rx_byte};
        if (note_end) begin
          // Final note: follow with the length write
          res_second.write_kind  = scd_pkg::KIND_LENGTH;
          res_second.payload     = {10'd0, note_total};
          res_second.last_of_run = 1'b1;
          res_count              = 2'd2;
        end else begin
          res_first.last_of_run = 1'b1;
          res_count             = 2'd1;
        end
      end
      scd_pkg::PH_SKIP: begin
        res_count = 2'd0;
      end
      default: begin
        if (rx_byte != cfg.code_gauge && rx_byte != cfg.code_bright &&
            rx_byte != cfg.code_display && rx_byte != cfg.code_audio &&
            rx_byte == cfg.code_flush) begin
          res_first.write_kind  = scd_pkg::KIND_REPLY;
          res_first.payload     = {8'd0, cfg.reply_flush_ack};
          res_first.last_of_run = 1'b1;
          res_count             = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= scd_pkg::PH_IDLE;
      command        <= scd_pkg::CMD_NONE;
      target_index   <= 8'd0;
      byte_position  <= 6'd0;
      note_total     <= 6'd0;
      skip_remaining <= 9'd0;
      note_high_hold <= 8'd0;
    end else if (take) begin
      phase          <= phase_next;
      command        <= command_next;
      target_index   <= target_index_next;
      byte_position  <= byte_position_next;
      note_total     <= note_total_next;
      skip_remaining <= skip_remaining_next;
      note_high_hold <= note_high_hold_next;
    end
  end

endmodule

// File: sv/scd_queue.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while head_ready is high.
module scd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  scd_pkg::result_t  push_first,
  input  scd_pkg::result_t  push_second,
  output logic              room,
  output logic              head_valid,
  input  logic              head_ready,
  output scd_pkg::result_t  head
);

  localparam int CW = scd_pkg::QUEUE_AW + 1;

  scd_pkg::result_t entries [scd_pkg::QUEUE_DEPTH];
  logic [scd_pkg::QUEUE_AW-1:0] wr_ptr, wr_ptr_next;
  logic [scd_pkg::QUEUE_AW-1:0] rd_ptr, rd_ptr_next;
  logic [scd_pkg::QUEUE_AW-1:0] wr_ptr_second;
  logic [CW-1:0] fill, fill_next;
  logic pop;

  assign head_valid    = fill != '0;
  assign head          = entries[rd_ptr];
  assign pop           = head_valid && head_ready;
  // keep space for a two-result word
  assign room          = fill <= CW'(scd_pkg::QUEUE_DEPTH - 2);
  assign wr_ptr_second = wr_ptr + 1'b1;
  assign wr_ptr_next   = wr_ptr + scd_pkg::QUEUE_AW'(push_count);
  assign rd_ptr_next   = rd_ptr + scd_pkg::QUEUE_AW'(pop);
  assign fill_next     = fill + CW'(push_count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_second] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

endmodule
